// File: rtl/tsi_pkg.sv
// ----------------------------------------------------------------------------
// tsi_pkg
// shared constants, types and helpers for the tdm sample interleaver
// ----------------------------------------------------------------------------
package tsi_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int MAX_SAMPLES  = 64;

    localparam int CH_W    = $clog2(MAX_CHANNELS);
    localparam int NCH_W   = 3;
    localparam int ROW_W   = $clog2(MAX_SAMPLES);
    localparam int CNT_W   = 7;
    localparam int LANE_W  = 16;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [1:0] REG_CHANNEL_COUNT     = 2'd0;
    localparam logic [1:0] REG_SAMPLE_BYTES      = 2'd1;
    localparam logic [1:0] REG_SAMPLES_PER_FRAME = 2'd2;
    localparam logic [1:0] REG_IDLE_BYTE         = 2'd3;

    localparam logic [NCH_W-1:0] RST_CHANNEL_COUNT     = 3'd2;
    localparam logic [1:0]       RST_SAMPLE_BYTES      = 2'd1;
    localparam logic [CNT_W-1:0] RST_SAMPLES_PER_FRAME = 7'd64;
    localparam logic [7:0]       RST_IDLE_BYTE         = 8'hff;

    typedef logic [LANE_W-1:0] lane_t;
    typedef lane_t [MAX_CHANNELS-1:0] row_t;
    typedef logic [MAX_CHANNELS-1:0][CNT_W-1:0] fill_vec_t;

    typedef struct packed {
        logic [NCH_W-1:0] channel_count;
        logic [1:0]       sample_bytes;
        logic [CNT_W-1:0] samples_per_frame;
        logic [7:0]       idle_byte;
    } cfg_t;

    typedef struct packed {
        logic [NCH_W-1:0] nch;
        logic             wide;
        logic [CNT_W-1:0] rows;
        lane_t            pad;
    } eff_t;

    function automatic eff_t eff_cfg(input cfg_t c);
        eff_t e;
        if (c.channel_count < NCH_W'(2))
            e.nch = NCH_W'(2);
        else if (c.channel_count > NCH_W'(MAX_CHANNELS))
            e.nch = NCH_W'(MAX_CHANNELS);
        else
            e.nch = c.channel_count;
        e.wide = (c.sample_bytes >= 2'd2);
        if (c.samples_per_frame == '0)
            e.rows = CNT_W'(1);
        else if (c.samples_per_frame > CNT_W'(MAX_SAMPLES))
            e.rows = CNT_W'(MAX_SAMPLES);
        else
            e.rows = c.samples_per_frame;
        e.pad = e.wide ? {c.idle_byte, c.idle_byte} : {8'h00, c.idle_byte};
        return e;
    endfunction

endpackage

// File: rtl/tsi_cfg_regs.sv
// ----------------------------------------------------------------------------
// tsi_cfg_regs
// apb register file for channel count, sample width, frame length, idle byte
// ----------------------------------------------------------------------------
module tsi_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsi_pkg::ADDR_W-1:0]  paddr,
    input  logic [tsi_pkg::DATA_W-1:0]  pwdata,
    output logic [tsi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output tsi_pkg::cfg_t               cfg,
    output logic                        cfg_wr
);
    import tsi_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [1:0] idx;

    assign pready = 1'b1;
    assign idx    = paddr[3:2];
    assign cfg_wr = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (idx)
                REG_CHANNEL_COUNT:     cfg_next.channel_count     = pwdata[NCH_W-1:0];
                REG_SAMPLE_BYTES:      cfg_next.sample_bytes      = pwdata[1:0];
                REG_SAMPLES_PER_FRAME: cfg_next.samples_per_frame = pwdata[CNT_W-1:0];
                REG_IDLE_BYTE:         cfg_next.idle_byte         = pwdata[7:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_CHANNEL_COUNT:     prdata = DATA_W'(cfg_reg.channel_count);
            REG_SAMPLE_BYTES:      prdata = DATA_W'(cfg_reg.sample_bytes);
            REG_SAMPLES_PER_FRAME: prdata = DATA_W'(cfg_reg.samples_per_frame);
            REG_IDLE_BYTE:         prdata = DATA_W'(cfg_reg.idle_byte);
            default:               prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.channel_count     <= RST_CHANNEL_COUNT;
            cfg_reg.sample_bytes      <= RST_SAMPLE_BYTES;
            cfg_reg.samples_per_frame <= RST_SAMPLES_PER_FRAME;
            cfg_reg.idle_byte         <= RST_IDLE_BYTE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/tsi_frame_ram.sv
// ----------------------------------------------------------------------------
// tsi_frame_ram
// frame store, one row per sample time, one lane written per request
// ----------------------------------------------------------------------------
module tsi_frame_ram (
    input  logic                       clk,
    input  logic                       we,
    input  logic [tsi_pkg::ROW_W-1:0]  waddr,
    input  logic [tsi_pkg::CH_W-1:0]   wlane,
    input  tsi_pkg::lane_t             wdata,
    input  logic                       re,
    input  logic [tsi_pkg::ROW_W-1:0]  raddr,
    output tsi_pkg::row_t              rdata
);
    import tsi_pkg::*;

    row_t mem [MAX_SAMPLES];
    row_t rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr][wlane] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

endmodule

// File: rtl/tsi_row_drain.sv
// ----------------------------------------------------------------------------
// tsi_row_drain
// reads out a finished frame row by row, pads short channels, drives rows
// ----------------------------------------------------------------------------
module tsi_row_drain (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  tsi_pkg::eff_t              eff,
    input  tsi_pkg::fill_vec_t         fill,
    output logic                       done,
    output logic                       re,
    output logic [tsi_pkg::ROW_W-1:0]  raddr,
    input  tsi_pkg::row_t              rdata,
    output logic                       out_valid,
    input  logic                       out_stall,
    output tsi_pkg::lane_t             lane0,
    output tsi_pkg::lane_t             lane1,
    output tsi_pkg::lane_t             lane2,
    output tsi_pkg::lane_t             lane3,
    output logic                       last_row
);
    import tsi_pkg::*;

    logic             busy_reg,  busy_next;
    logic [CNT_W-1:0] iss_reg,   iss_next;
    logic             pend_reg,  pend_next;
    logic [ROW_W-1:0] rrow_reg,  rrow_next;
    logic             ovld_reg,  ovld_next;
    row_t             orow_reg,  orow_next;
    logic             olast_reg, olast_next;
    row_t             padded;
    logic             is_last;

    assign re       = busy_reg && (iss_reg < eff.rows) && !pend_reg
                      && (!ovld_reg || !out_stall);
    assign raddr    = iss_reg[ROW_W-1:0];
    assign is_last  = ({1'b0, rrow_reg} + CNT_W'(1)) == eff.rows;
    assign done     = pend_reg && is_last;

    assign out_valid = ovld_reg;
    assign lane0     = orow_reg[0];
    assign lane1     = orow_reg[1];
    assign lane2     = orow_reg[2];
    assign lane3     = orow_reg[3];
    assign last_row  = olast_reg;

    always_comb
    begin
        for (int l = 0; l < MAX_CHANNELS; l++)
        begin
            if (NCH_W'(l) >= eff.nch)
                padded[l] = '0;
            else if ({1'b0, rrow_reg} < fill[l])
                padded[l] = rdata[l];
            else
                padded[l] = eff.pad;
        end
    end

    always_comb
    begin
        busy_next  = busy_reg;
        iss_next   = iss_reg;
        pend_next  = pend_reg;
        rrow_next  = rrow_reg;
        ovld_next  = ovld_reg;
        orow_next  = orow_reg;
        olast_next = olast_reg;

        if (ovld_reg && !out_stall)
            ovld_next = 1'b0;

        if (start)
        begin
            busy_next = 1'b1;
            iss_next  = '0;
        end

        if (re)
        begin
            pend_next = 1'b1;
            rrow_next = iss_reg[ROW_W-1:0];
            iss_next  = iss_reg + CNT_W'(1);
        end

        if (pend_reg)
        begin
            pend_next  = 1'b0;
            ovld_next  = 1'b1;
            orow_next  = padded;
            olast_next = is_last;
            if (is_last)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            iss_reg  <= '0;
            pend_reg <= 1'b0;
            ovld_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            iss_reg  <= iss_next;
            pend_reg <= pend_next;
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rrow_reg  <= rrow_next;
        orow_reg  <= orow_next;
        olast_reg <= olast_next;
    end

endmodule

// File: rtl/tdm_sample_interleaver.sv
// ----------------------------------------------------------------------------
// tdm_sample_interleaver
// collects channel-tagged samples into a frame store and forwards full frames
// as interleaved rows
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall   channel, sample
//   out      from block out_valid / out_stall lane0..lane3, last_row
//   cfg      to block   apb psel / penable    paddr, pwdata, prdata
//
// a sample that does not complete the frame is written as it is accepted
// a forwarded frame is read out row by row with one row in flight at a time,
// each row going from the single frame store read port to the output register
// and a sample that finds its channel full waits for that drain before its write
// the frame store needs no clearing pass after reset; unwritten slots are padded
// in_stall stays high while a frame drains; out_stall holds the current row
// ----------------------------------------------------------------------------
module tdm_sample_interleaver (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsi_pkg::ADDR_W-1:0]  paddr,
    input  logic [tsi_pkg::DATA_W-1:0]  pwdata,
    output logic [tsi_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tsi_pkg::CH_W-1:0]    channel,
    input  logic [15:0]                 sample,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [15:0]                 lane0,
    output logic [15:0]                 lane1,
    output logic [15:0]                 lane2,
    output logic [15:0]                 lane3,
    output logic                        last_row
);
    import tsi_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DRAIN = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    cfg_t             cfg;
    logic             cfg_wr;
    eff_t             eff;

    logic [1:0]       state_reg, state_next;
    fill_vec_t        fill_reg,  fill_next;
    logic [NCH_W-1:0] full_reg,  full_next;
    logic             pwr_reg,   pwr_next;
    logic [CH_W-1:0]  hch_reg,   hch_next;
    lane_t            hsmp_reg,  hsmp_next;

    logic             accept;
    logic             ch_ok;
    logic [CNT_W-1:0] cur_fill;
    lane_t            smp;
    logic [NCH_W-1:0] full_inc;

    logic             we;
    logic [ROW_W-1:0] waddr;
    logic [CH_W-1:0]  wlane;
    lane_t            wdata;
    logic             start;
    logic             done;
    logic             re;
    logic [ROW_W-1:0] raddr;
    row_t             rdata;

    tsi_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .cfg_wr  (cfg_wr)
    );

    assign eff = eff_cfg(cfg);

    tsi_frame_ram u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wlane (wlane),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    tsi_row_drain u_drain (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .eff       (eff),
        .fill      (fill_reg),
        .done      (done),
        .re        (re),
        .raddr     (raddr),
        .rdata     (rdata),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .lane0     (lane0),
        .lane1     (lane1),
        .lane2     (lane2),
        .lane3     (lane3),
        .last_row  (last_row)
    );

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign ch_ok    = {1'b0, channel} < eff.nch;
    assign cur_fill = fill_reg[channel];
    assign smp      = eff.wide ? sample : {8'h00, sample[7:0]};
    assign full_inc = full_reg + NCH_W'((cur_fill + CNT_W'(1)) == eff.rows);

    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        full_next  = full_reg;
        pwr_next   = pwr_reg;
        hch_next   = hch_reg;
        hsmp_next  = hsmp_reg;
        we         = 1'b0;
        waddr      = cur_fill[ROW_W-1:0];
        wlane      = channel;
        wdata      = smp;
        start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_wr)
                begin
                    fill_next = '0;
                    full_next = '0;
                end
                else if (accept && ch_ok)
                begin
                    if (cur_fill >= eff.rows)
                    begin
                        hch_next   = channel;
                        hsmp_next  = smp;
                        pwr_next   = 1'b1;
                        start      = 1'b1;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        we                 = 1'b1;
                        fill_next[channel] = cur_fill + CNT_W'(1);
                        full_next          = full_inc;
                        if (full_inc == eff.nch)
                        begin
                            pwr_next   = 1'b0;
                            start      = 1'b1;
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (done)
                begin
                    fill_next  = '0;
                    full_next  = '0;
                    state_next = pwr_reg ? ST_WRITE : ST_IDLE;
                end
            end
            ST_WRITE:
            begin
                we                 = 1'b1;
                waddr              = '0;
                wlane              = hch_reg;
                wdata              = hsmp_reg;
                fill_next[hch_reg] = CNT_W'(1);
                full_next          = NCH_W'(eff.rows == CNT_W'(1));
                pwr_next           = 1'b0;
                state_next         = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            full_reg  <= '0;
            pwr_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            full_reg  <= full_next;
            pwr_reg   <= pwr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hch_reg  <= hch_next;
        hsmp_reg <= hsmp_next;
    end

endmodule
